>>> design/pds_pkg.sv
// shared types and constants of the polyphase 8-tap downscaler
package pds_pkg;

    localparam int TAP_COUNT   = 8;
    localparam int SAMPLE_W    = 8;
    localparam int COEFF_W     = 8;
    localparam int PROD_W      = 16;
    localparam int SUM_W       = 19;
    localparam int ROUND_ADD   = 64;
    localparam int ROUND_SHIFT = 7;
    localparam int MAX_ROW     = 4096;
    localparam int COUNT_W     = 13;
    localparam int INDEX_W     = 12;
    localparam int PIXEL_MAX   = 255;

    localparam logic OP_SAMPLE     = 1'b0;
    localparam logic OP_COEFF_LOAD = 1'b1;

    localparam logic [1:0] REG_INIT_OFFSET = 2'd0;
    localparam logic [1:0] REG_STEP_INC    = 2'd1;
    localparam logic [1:0] REG_CHROMA_MODE = 2'd2;
    localparam logic [1:0] REG_OUT_WIDTH   = 2'd3;

    typedef struct packed {
        logic shift_a;
        logic shift_b;
        logic sel_b;
        logic load;
    } t_cell_ctrl;

    typedef struct packed {
        logic                 plane;
        logic [INDEX_W-1:0]   index;
        logic                 last;
    } t_out_meta;

    typedef logic [TAP_COUNT-1:0][PROD_W-1:0] t_prod_vec;

endpackage

>>> design/polyphase_8tap_downscaler.sv
// polyphase 8-tap downscaler: control, coefficient table, cell chain, output stage
// path: a result is registered in the tap-cell product registers, then in the output register
// throughput: one transaction per cycle, set by the window shift in the cell row
// and the two-stage product/sum pipeline; the input stalls only while both stages are full
// reset (synchronous, active low): windows zero, row counters cleared, position = init offset,
// registers at their defaults; the coefficient table holds garbage until its rows are loaded
module polyphase_8tap_downscaler
    import pds_pkg::*;
#(
    parameter int PHASE_COUNT = 8,
    parameter int FRAC_BITS   = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input channel
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic                   i_opcode,
    input  logic [7:0]             i_sample,
    input  logic                   i_last_in_row,
    input  logic [2:0]             i_coeff_phase,
    input  logic [63:0]            i_coeff_word,
    // output channel
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [7:0]             o_pixel,
    output logic                   o_plane,
    output logic [11:0]            o_out_index,
    output logic                   o_last_of_row,
    // configuration port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [3:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int PW = (PHASE_COUNT > 1) ? $clog2(PHASE_COUNT) : 1;
    localparam int NW = 32 - FRAC_BITS;
    localparam int MW = FRAC_BITS + 6;

    // configuration registers
    logic [27:0]          r_init_offset, n_init_offset;
    logic [19:0]          r_step, n_step;
    logic                 r_chroma, n_chroma;
    logic [COUNT_W-1:0]   r_out_width, n_out_width;

    // row state
    logic [31:0]          r_position, n_position;
    logic [PW-1:0]        r_phase, n_phase;
    logic [COUNT_W-1:0]   r_sample_count, n_sample_count;
    logic [COUNT_W-1:0]   r_output_count, n_output_count;
    logic                 r_toggle, n_toggle;

    // coefficient table, one 64-bit row per phase
    logic [63:0]          r_coeff [PHASE_COUNT];

    // product stage
    logic                 r_s1_valid;
    t_out_meta            r_s1_meta;

    logic                 w_accept, w_acc_sample, w_acc_coeff, w_cfg_wr;
    logic                 w_plane, w_hit, w_produce, w_advance, w_restart;
    logic                 w_s1_adv, w_out_valid;
    logic [COUNT_W-1:0]   w_eff_width;
    logic [NW-1:0]        w_n;
    logic [63:0]          w_coeff_row;
    t_cell_ctrl           w_ctrl;
    t_out_meta            w_meta, w_out_meta;
    t_prod_vec            w_prod;
    logic [MW-1:0]        w_phase_mult;

    logic [SAMPLE_W-1:0]  w_win_a [TAP_COUNT];
    logic [SAMPLE_W-1:0]  w_win_b [TAP_COUNT];

    // handshakes: the product stage moves on when the output register is free
    assign w_s1_adv     = !w_out_valid || i_out_ready;
    assign o_in_ready   = !r_s1_valid || w_s1_adv;
    assign w_accept     = i_in_valid && o_in_ready;
    assign w_acc_sample = w_accept && (i_opcode == OP_SAMPLE);
    assign w_acc_coeff  = w_accept && (i_opcode == OP_COEFF_LOAD);
    assign w_cfg_wr     = psel && penable && pwrite;
    assign pready       = 1'b1;

    // plane of this transaction and the output decision
    assign w_plane     = r_chroma && r_toggle;
    assign w_eff_width = ({1'b0, r_out_width} < (COUNT_W+1)'(MAX_ROW)) ?
                         r_out_width : COUNT_W'(MAX_ROW);
    assign w_n         = r_position[31:FRAC_BITS];
    assign w_hit       = (33'(w_n) + 33'(TAP_COUNT)) == 33'(r_sample_count);
    assign w_produce   = w_acc_sample && w_hit && (r_output_count < w_eff_width);
    // position and counters move after the single plane or after the Cr sample
    assign w_advance   = !r_chroma || w_plane;

    assign w_meta.plane = w_plane;
    assign w_meta.index = r_output_count[INDEX_W-1:0];
    assign w_meta.last  = ({1'b0, r_output_count} + 14'd1) == {1'b0, w_eff_width};

    always_comb begin
        n_init_offset  = r_init_offset;
        n_step         = r_step;
        n_chroma       = r_chroma;
        n_out_width    = r_out_width;
        n_position     = r_position;
        n_sample_count = r_sample_count;
        n_output_count = r_output_count;
        n_toggle       = r_toggle;
        w_restart      = 1'b0;

        if (w_acc_sample) begin
            if (w_advance) begin
                if (r_sample_count != {COUNT_W{1'b1}}) begin
                    n_sample_count = r_sample_count + 1'b1;
                end
                if (w_produce) begin
                    n_output_count = r_output_count + 1'b1;
                    n_position     = r_position + 32'(r_step);
                end
            end
            n_toggle  = r_toggle ^ r_chroma;
            w_restart = i_last_in_row;
        end

        if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_INIT_OFFSET: n_init_offset = pwdata[27:0];
                REG_STEP_INC:    n_step        = pwdata[19:0];
                REG_CHROMA_MODE: n_chroma      = pwdata[0];
                REG_OUT_WIDTH:   n_out_width   = pwdata[COUNT_W-1:0];
                default:         n_chroma      = r_chroma;
            endcase
            w_restart = 1'b1;
        end

        // row restart: reload position, clear counters, windows kept
        if (w_restart) begin
            n_position     = 32'(n_init_offset);
            n_sample_count = '0;
            n_output_count = '0;
            n_toggle       = 1'b0;
        end

        // phase follows the fraction of the next position, kept registered
        w_phase_mult = MW'(n_position[FRAC_BITS-1:0]) * MW'(PHASE_COUNT);
        n_phase      = w_phase_mult[FRAC_BITS +: PW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_offset  <= '0;
            r_step         <= 20'h10000;
            r_chroma       <= 1'b0;
            r_out_width    <= COUNT_W'(1);
            r_position     <= '0;
            r_phase        <= '0;
            r_sample_count <= '0;
            r_output_count <= '0;
            r_toggle       <= 1'b0;
            r_s1_valid     <= 1'b0;
        end else begin
            r_init_offset  <= n_init_offset;
            r_step         <= n_step;
            r_chroma       <= n_chroma;
            r_out_width    <= n_out_width;
            r_position     <= n_position;
            r_phase        <= n_phase;
            r_sample_count <= n_sample_count;
            r_output_count <= n_output_count;
            r_toggle       <= n_toggle;
            if (o_in_ready) begin
                r_s1_valid <= w_produce;
            end
        end
    end

    // meta of the item whose products sit in the cells
    always_ff @(posedge i_clk) begin
        if (w_produce) begin
            r_s1_meta <= w_meta;
        end
    end

    // coefficient rows; a phase beyond the table is dropped
    always_ff @(posedge i_clk) begin
        if (w_acc_coeff && (32'(i_coeff_phase) < PHASE_COUNT)) begin
            r_coeff[PW'(i_coeff_phase)] <= i_coeff_word;
        end
    end

    assign w_coeff_row = r_coeff[r_phase];

    assign w_ctrl.shift_a = w_acc_sample && !w_plane;
    assign w_ctrl.shift_b = w_acc_sample && w_plane;
    assign w_ctrl.sel_b   = w_plane;
    assign w_ctrl.load    = w_produce;

    // row of tap cells: samples enter at the top cell and move down one slot per sample
    for (genvar t = 0; t < TAP_COUNT; t++) begin : g_cell
        logic [SAMPLE_W-1:0] w_nb_a;
        logic [SAMPLE_W-1:0] w_nb_b;

        if (t == TAP_COUNT - 1) begin : g_top
            assign w_nb_a = i_sample;
            assign w_nb_b = i_sample;
        end else begin : g_mid
            assign w_nb_a = w_win_a[t+1];
            assign w_nb_b = w_win_b[t+1];
        end

        pds_tap_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_nb_a  (w_nb_a),
            .i_nb_b  (w_nb_b),
            .i_coeff (w_coeff_row[COEFF_W*t +: COEFF_W]),
            .o_win_a (w_win_a[t]),
            .o_win_b (w_win_b[t]),
            .o_prod  (w_prod[t])
        );
    end

    pds_round_clip u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_prod  (w_prod),
        .i_valid (r_s1_valid),
        .i_meta  (r_s1_meta),
        .i_adv   (w_s1_adv),
        .o_valid (w_out_valid),
        .o_pixel (o_pixel),
        .o_meta  (w_out_meta)
    );

    assign o_out_valid   = w_out_valid;
    assign o_plane       = w_out_meta.plane;
    assign o_out_index   = w_out_meta.index;
    assign o_last_of_row = w_out_meta.last;

    // register readback
    always_comb begin
        case (paddr[3:2])
            REG_INIT_OFFSET: prdata = 32'(r_init_offset);
            REG_STEP_INC:    prdata = 32'(r_step);
            REG_CHROMA_MODE: prdata = 32'(r_chroma);
            REG_OUT_WIDTH:   prdata = 32'(r_out_width);
            default:         prdata = '0;
        endcase
    end

endmodule

>>> design/pds_tap_cell.sv
// one tap cell: holds one window slot per plane and registers its product
module pds_tap_cell
    import pds_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cell_ctrl                 i_ctrl,
    input  logic [SAMPLE_W-1:0]        i_nb_a,
    input  logic [SAMPLE_W-1:0]        i_nb_b,
    input  logic [COEFF_W-1:0]         i_coeff,
    output logic [SAMPLE_W-1:0]        o_win_a,
    output logic [SAMPLE_W-1:0]        o_win_b,
    output logic [PROD_W-1:0]          o_prod
);

    logic [SAMPLE_W-1:0]   r_win_a;
    logic [SAMPLE_W-1:0]   r_win_b;
    logic [PROD_W-1:0]     r_prod;
    logic [SAMPLE_W-1:0]   w_new;
    logic signed [SAMPLE_W+COEFF_W:0] w_mult;

    // the window of the current plane after its shift
    assign w_new  = i_ctrl.sel_b ? i_nb_b : i_nb_a;
    assign w_mult = $signed({1'b0, w_new}) * $signed(i_coeff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_a <= '0;
            r_win_b <= '0;
        end else begin
            if (i_ctrl.shift_a) begin
                r_win_a <= i_nb_a;
            end
            if (i_ctrl.shift_b) begin
                r_win_b <= i_nb_b;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_prod <= w_mult[PROD_W-1:0];
        end
    end

    assign o_win_a = r_win_a;
    assign o_win_b = r_win_b;
    assign o_prod  = r_prod;

endmodule

>>> design/pds_round_clip.sv
// sum of tap products, rounding, clipping and the output register
module pds_round_clip
    import pds_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_prod_vec             i_prod,
    input  logic                  i_valid,
    input  t_out_meta             i_meta,
    input  logic                  i_adv,
    output logic                  o_valid,
    output logic [SAMPLE_W-1:0]   o_pixel,
    output t_out_meta             o_meta
);

    logic                         r_valid;
    logic [SAMPLE_W-1:0]          r_pixel;
    t_out_meta                    r_meta;
    logic signed [SUM_W-1:0]      w_sum;
    logic signed [SUM_W-1:0]      w_shift;
    logic [SAMPLE_W-1:0]          w_pixel;

    always_comb begin
        w_sum = SUM_W'(ROUND_ADD);
        for (int t = 0; t < TAP_COUNT; t++) begin
            w_sum = w_sum + SUM_W'($signed(i_prod[t]));
        end
        w_shift = w_sum >>> ROUND_SHIFT;
        if (w_sum < 0) begin
            w_pixel = '0;
        end else if (w_shift > SUM_W'(PIXEL_MAX)) begin
            w_pixel = SAMPLE_W'(PIXEL_MAX);
        end else begin
            w_pixel = w_shift[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_valid) begin
            r_pixel <= w_pixel;
            r_meta  <= i_meta;
        end
    end

    assign o_valid = r_valid;
    assign o_pixel = r_pixel;
    assign o_meta  = r_meta;

endmodule

>>> test/tb.sv
// testbench of the polyphase 8-tap downscaler: directed table, then randomized rows
module tb;
    import pds_pkg::*;

    localparam int PHASES  = 8;      // coefficient phases, matches the default instance
    localparam int FRAC    = 16;     // fraction bits of the source position
    localparam int CNT_SAT = 8191;   // sample counter saturation value
    localparam int SETTLE  = 8;      // idle cycles after the last pending pixel

    // one output transaction
    typedef struct packed {
        logic [7:0]  pixel;
        logic        plane;
        logic [11:0] index;
        logic        last;
    } t_scaled_px;

    // one row of the directed table
    typedef struct {
        logic        op;
        logic [7:0]  smp;
        logic        row_end;
        logic [2:0]  cphase;
        logic [63:0] cword;
        logic        typed;
        t_scaled_px  px;
    } t_dir_row;

    // stimulus side, every input known from time zero
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        op        = OP_SAMPLE;
    logic [7:0]  smp       = '0;
    logic        row_end   = 1'b0;
    logic [2:0]  cphase    = '0;
    logic [63:0] cword     = '0;
    logic        out_ready = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [3:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;

    // block outputs
    logic        in_ready;
    logic        out_valid;
    logic [7:0]  pixel;
    logic        plane;
    logic [11:0] out_idx;
    logic        out_last;
    logic [31:0] prdata;
    logic        pready;

    // predictor copy of the registers
    logic [27:0] cfg_offset;
    logic [19:0] cfg_step;
    logic        cfg_chroma;
    logic [12:0] cfg_width;

    // predictor copy of the datapath state
    logic [7:0]  luma_cb_win [TAP_COUNT];
    logic [7:0]  cr_win [TAP_COUNT];
    logic [63:0] tap_rows [PHASES];
    logic [31:0] src_pos;
    int          src_cnt;
    int          dst_cnt;
    logic        cr_turn;

    t_scaled_px  pending_px [$];     // pixels predicted and not yet seen
    t_dir_row    script [$];
    int          errors    = 0;
    int          send_idle = 0;      // percent of cycles the sender holds back
    int          recv_idle = 0;      // percent of cycles the receiver stalls
    logic        row_typed = 1'b0;   // current transaction carries a hand-typed expectation
    t_scaled_px  row_expect = '0;

    polyphase_8tap_downscaler i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_opcode      (op),
        .i_sample      (smp),
        .i_last_in_row (row_end),
        .i_coeff_phase (cphase),
        .i_coeff_word  (cword),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_pixel       (pixel),
        .o_plane       (plane),
        .o_out_index   (out_idx),
        .o_last_of_row (out_last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // row restart: position reloads, counters and plane toggle clear, windows kept
    function automatic void restart_row();
        src_pos = {4'd0, cfg_offset};
        src_cnt = 0;
        dst_cnt = 0;
        cr_turn = 1'b0;
    endfunction

    // 8-tap dot product, round, clip; negative sums land at zero
    function automatic logic [7:0] fir_pixel(input logic pl, input int ph);
        int acc;
        int c;
        int t;
        acc = 0;
        for (t = 0; t < TAP_COUNT; t++) begin
            c = $signed(tap_rows[ph][8*t +: 8]);
            acc += (pl ? int'(cr_win[t]) : int'(luma_cb_win[t])) * c;
        end
        acc += ROUND_ADD;
        if (acc < 0)
            return '0;
        acc = acc >>> ROUND_SHIFT;
        return (acc > PIXEL_MAX) ? 8'(PIXEL_MAX) : 8'(acc);
    endfunction

    // one source sample: shift the plane window, maybe emit, advance counters
    function automatic void take_sample(input logic [7:0] s, input logic row_end_in);
        logic       pl;
        logic       fire;
        int         eff_w;
        int         n;
        int         ph;
        int         t;
        t_scaled_px px;
        pl = cfg_chroma & cr_turn;
        for (t = 0; t < TAP_COUNT - 1; t++) begin
            if (pl)
                cr_win[t] = cr_win[t+1];
            else
                luma_cb_win[t] = luma_cb_win[t+1];
        end
        if (pl)
            cr_win[TAP_COUNT-1] = s;
        else
            luma_cb_win[TAP_COUNT-1] = s;

        eff_w = (cfg_width < MAX_ROW) ? int'(cfg_width) : MAX_ROW;
        n     = int'(src_pos >> FRAC);
        ph    = int'((32'(src_pos[FRAC-1:0]) * PHASES) >> FRAC);
        fire  = (dst_cnt < eff_w) && (n + TAP_COUNT == src_cnt);
        px    = '0;
        if (fire) begin
            px.pixel = fir_pixel(pl, ph);
            px.plane = pl;
            px.index = dst_cnt[11:0];
            px.last  = (dst_cnt + 1 == eff_w);
        end
        if (row_typed)
            pending_px.push_back(row_expect);
        else if (fire)
            pending_px.push_back(px);

        // position moves once per sample pair in chroma mode, after the cr sample
        if (!cfg_chroma || pl) begin
            if (src_cnt < CNT_SAT)
                src_cnt++;
            if (fire) begin
                dst_cnt++;
                src_pos += cfg_step;
            end
        end
        if (cfg_chroma)
            cr_turn = ~cr_turn;
        if (row_end_in)
            restart_row();
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // ------------------------------------------------------------------
    // monitor: input transactions feed the predictor, output transactions are checked
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        t_scaled_px want;
        if (rst_n) begin
            if (in_valid && in_ready) begin
                if (op == OP_COEFF_LOAD)
                    tap_rows[cphase] = cword;   // row-end flag has no effect on a load
                else
                    take_sample(smp, row_end);
            end
            if (out_valid && out_ready) begin
                if (pending_px.size() == 0) begin
                    $error("unexpected output transaction: pixel %0d plane %0d index %0d",
                           pixel, plane, out_idx);
                    errors++;
                end else begin
                    want = pending_px.pop_front();
                    check_field("pixel", 32'(want.pixel), 32'(pixel));
                    check_field("plane", 32'(want.plane), 32'(plane));
                    check_field("out_index", 32'(want.index), 32'(out_idx));
                    check_field("last_of_row", 32'(want.last), 32'(out_last));
                end
            end
        end
    end

    // receiver backpressure
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle);

    // ------------------------------------------------------------------
    // drivers, all entered and left at a falling edge
    // ------------------------------------------------------------------

    // present one transaction and hold it until accepted
    task automatic send_item(input logic o, input logic [7:0] s, input logic re,
                             input logic [2:0] cp, input logic [63:0] cw,
                             input logic typed, input t_scaled_px px);
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        op         <= o;
        smp        <= s;
        row_end    <= re;
        cphase     <= cp;
        cword      <= cw;
        row_typed  = typed;
        row_expect = px;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // sender holds off until every pending pixel is out, then lets the pipe settle
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_px.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_INIT_OFFSET: cfg_offset = val[27:0];
            REG_STEP_INC:    cfg_step   = val[19:0];
            REG_CHROMA_MODE: cfg_chroma = val[0];
            default:         cfg_width  = val[12:0];
        endcase
        restart_row();
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic reg_read(input logic [1:0] idx, output logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        val = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // program all four registers with junk above the field, then read them back
    task automatic set_regs(input logic [27:0] off, input logic [19:0] stp,
                            input logic chr, input logic [12:0] wid);
        logic [31:0] rb;
        logic [31:0] want;
        int          k;
        reg_write(REG_INIT_OFFSET, {4'($urandom), off});
        reg_write(REG_STEP_INC, {12'($urandom), stp});
        reg_write(REG_CHROMA_MODE, {31'($urandom), chr});
        reg_write(REG_OUT_WIDTH, {19'($urandom), wid});
        for (k = 0; k < 4; k++) begin
            reg_read(2'(k), rb);
            case (2'(k))
                REG_INIT_OFFSET: want = 32'(cfg_offset);
                REG_STEP_INC:    want = 32'(cfg_step);
                REG_CHROMA_MODE: want = 32'(cfg_chroma);
                default:         want = 32'(cfg_width);
            endcase
            check_field("register readback", want, rb);
        end
    endtask

    // half fully random rows, half small positive taps near unity gain
    function automatic logic [63:0] random_taps();
        logic [63:0] w;
        int          t;
        if ($urandom_range(1))
            w = {$urandom, $urandom};
        else
            for (t = 0; t < TAP_COUNT; t++)
                w[8*t +: 8] = 8'($urandom_range(32));
        return w;
    endfunction

    // mostly complete rows with random content, some runt rows, stray row ends
    // and coefficient reloads mixed in; the last row is cut to fit the budget
    task automatic stream_rows(input int budget);
        int         sent;
        int         per_row;
        int         k;
        logic       re;
        t_scaled_px no_px;
        no_px = '0;
        sent  = 0;
        while (sent < budget) begin
            per_row = $urandom_range(9, 40) * (cfg_chroma ? 2 : 1);
            if ($urandom_range(9) == 0)
                per_row = $urandom_range(1, 8);
            if (per_row > budget - sent)
                per_row = budget - sent;
            for (k = 0; k < per_row; k++) begin
                if ($urandom_range(19) == 0) begin
                    send_item(OP_COEFF_LOAD, 8'($urandom), 1'($urandom), 3'($urandom),
                              random_taps(), 1'b0, no_px);
                    sent++;
                end
                re = (k == per_row - 1) || ($urandom_range(49) == 0);
                send_item(OP_SAMPLE, 8'($urandom), re, 3'($urandom), {$urandom, $urandom},
                          1'b0, no_px);
                sent++;
            end
        end
    endtask

    function automatic void add_row(input logic o, input logic [7:0] s, input logic re,
                                    input logic [2:0] cp, input logic [63:0] cw,
                                    input logic typed, input t_scaled_px px);
        t_dir_row r;
        r.op      = o;
        r.smp     = s;
        r.row_end = re;
        r.cphase  = cp;
        r.cword   = cw;
        r.typed   = typed;
        r.px      = px;
        script.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        int          k;
        int          ph;
        logic [27:0] off;
        logic [19:0] stp;
        logic        chr;
        logic [12:0] wid;
        t_scaled_px  no_px;
        no_px = '0;

        // predictor at reset: default registers, zero windows
        cfg_offset = '0;
        cfg_step   = 20'h10000;
        cfg_chroma = 1'b0;
        cfg_width  = 13'd1;
        foreach (luma_cb_win[k]) begin
            luma_cb_win[k] = '0;
            cr_win[k]      = '0;
        end
        foreach (tap_rows[k])
            tap_rows[k] = '0;
        restart_row();

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table at reset defaults: one output per row, on the ninth sample
        // all taps +127 over a saturated window clips high; row-end flag on a load is ignored
        add_row(OP_COEFF_LOAD, 8'h00, 1'b1, 3'd0, {8{8'h7F}}, 1'b0, no_px);
        for (k = 0; k < 8; k++)
            add_row(OP_SAMPLE, 8'hFF, 1'b0, 3'd7, '0, 1'b0, no_px);
        add_row(OP_SAMPLE, 8'hFF, 1'b1, 3'd0, '1, 1'b1, {8'd255, 1'b0, 12'd0, 1'b1});
        // all taps -128 loaded mid row with the row-end flag set: negative sum gives zero
        for (k = 0; k < 4; k++)
            add_row(OP_SAMPLE, k[0] ? 8'h00 : 8'hFF, 1'b0, 3'd0, '0, 1'b0, no_px);
        add_row(OP_COEFF_LOAD, 8'hFF, 1'b1, 3'd0, {8{8'h80}}, 1'b0, no_px);
        for (k = 0; k < 4; k++)
            add_row(OP_SAMPLE, k[0] ? 8'hFF : 8'h00, 1'b0, 3'd5, '0, 1'b0, no_px);
        add_row(OP_SAMPLE, 8'h00, 1'b1, 3'd0, '0, 1'b1, {8'd0, 1'b0, 12'd0, 1'b1});
        // remaining phases get unity-gain rows so no unwritten row is ever read
        for (k = 1; k < PHASES; k++)
            add_row(OP_COEFF_LOAD, 8'(k * 37), k[0], 3'(k),
                    {8'(256 - k), 8'd8, 8'd24, 8'd32, 8'd32, 8'd24, 8'd8, 8'(k)},
                    1'b0, no_px);

        send_idle = 17;
        recv_idle = 88;
        foreach (script[k])
            send_item(script[k].op, script[k].smp, script[k].row_end, script[k].cphase,
                      script[k].cword, script[k].typed, script[k].px);
        drain();

        // randomized phases, registers rewritten only with the block idle
        for (ph = 0; ph < 12; ph++) begin
            send_idle = (ph < 4) ? 17 : (ph < 8) ? 88 : 0;
            recv_idle = (ph < 4) ? 88 : (ph < 8) ? 17 : 0;
            case (ph)
                0: begin
                    // widest step, chroma, width above the row limit
                    off = '0; stp = 20'hFFFFF; chr = 1'b1; wid = 13'd8191;
                end
                1: begin
                    // far offset, zero step, zero width: no outputs at all
                    off = 28'hFFFFFFF; stp = '0; chr = 1'b0; wid = '0;
                end
                2: begin
                    // step below unity, width at the row limit
                    off = 28'($urandom_range(3 << 16)); stp = 20'($urandom_range(65535));
                    chr = 1'b1; wid = 13'd4096;
                end
                3: begin
                    off = '0; stp = 20'h10000; chr = 1'b0; wid = 13'd1;
                end
                default: begin
                    off = ($urandom_range(7) == 0) ? 28'($urandom)
                                                   : 28'($urandom_range(6 << 16));
                    case ($urandom_range(5))
                        0:       stp = 20'($urandom_range(65535));
                        1:       stp = 20'($urandom_range(65536, 20'hFFFFF));
                        default: stp = 20'($urandom_range(65536, 3 << 16));
                    endcase
                    chr = 1'($urandom);
                    case ($urandom_range(7))
                        0:       wid = '0;
                        1:       wid = 13'($urandom);
                        default: wid = 13'($urandom_range(1, 12));
                    endcase
                end
            endcase
            set_regs(off, stp, chr, wid);
            if (ph == 5) begin
                // sender pauses mid stream until the output side is empty
                stream_rows(25);
                drain();
                stream_rows(25);
            end else begin
                stream_rows(50);
            end
            drain();
        end

        if (errors == 0)
            $display("[polyphase_8tap_downscaler] OK");
        else
            $display("[polyphase_8tap_downscaler] ERROR");
        $finish;
    end

    // watchdog
    initial begin
        #5000000;
        $display("[polyphase_8tap_downscaler] ERROR");
        $finish;
    end

endmodule
